/* design/cst_pkg.sv */
`timescale 1ns / 1ps
package cst_pkg;

	// Fixed-point formats
	localparam int FRAC_BITS  = 14;
	localparam int INT_BITS   = 30;
	localparam int MAX_SLICES = 16383;
	localparam int MIN_SLICES = 3;

	// Working widths
	localparam int IDX_W  = 14;
	localparam int NUM_W  = IDX_W + 3;  // 4*(i+1) fits here
	localparam int CRD_W  = 33;         // signed CORDIC datapath
	localparam int ANG_W  = 31;         // residual angle, Q30 radians
	localparam int OUT_W  = 16;
	localparam int MAG_W  = 15;

	// pi/2 in Q30, doubled for the rounding divide
	localparam logic [31:0] HALF_PI_X2 = 32'd3373259426;
	localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [MAG_W-1:0] TOP_HEIGHT = MAG_W'(1 << FRAC_BITS);

	// Quadrant divider: one quotient bit per step
	localparam int QD_BITS   = NUM_W;
	localparam int QD_PER    = 3;
	localparam int QD_STAGES = (QD_BITS + QD_PER - 1) / QD_PER;

	// Angle divider
	localparam int AD_BITS   = ANG_W;
	localparam int AD_PER    = 4;
	localparam int AD_STAGES = (AD_BITS + AD_PER - 1) / AD_PER;

	// CORDIC rotations
	localparam int CD_ITERS  = INT_BITS;
	localparam int CD_PER    = 2;
	localparam int CD_STAGES = (CD_ITERS + CD_PER - 1) / CD_PER;

	// Input to result register, in pipeline stages
	localparam int LANE_LAT = QD_STAGES + 1 + AD_STAGES + CD_STAGES + 1;

	// Result record kinds
	localparam logic KIND_VERTEX   = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;

	// Result slots of one slice
	localparam logic [2:0] SLOT_TRI_A = 3'd4;
	localparam logic [2:0] SLOT_TRI_B = 3'd5;

	// Sine/cosine pair of one angle
	typedef struct packed {
		logic signed [OUT_W-1:0] sn;
		logic signed [OUT_W-1:0] cs;
	} trig_t;

	// Arctangent of 2^-k in Q30
	function automatic logic signed [CRD_W-1:0] arc_of(input int k);
		logic signed [CRD_W-1:0] a;
		case (k)
			0: a = 33'sd843314857;
			1: a = 33'sd497837829;
			2: a = 33'sd263043837;
			3: a = 33'sd133525159;
			4: a = 33'sd67021687;
			5: a = 33'sd33543516;
			6: a = 33'sd16775851;
			7: a = 33'sd8388437;
			8: a = 33'sd4194283;
			9: a = 33'sd2097149;
			default: a = CRD_W'(64'sd1 << (INT_BITS - k));
		endcase
		return a;
	endfunction

	// Clamp to [0, 1] and round half up to the output format
	function automatic logic [MAG_W-1:0] to_out(input logic signed [CRD_W-1:0] v);
		logic [CRD_W-1:0] c;
		logic [CRD_W:0] r;
		if (v[CRD_W-1])
			c = '0;
		else if (v > (CRD_W'(64'sd1 << INT_BITS)))
			c = CRD_W'(64'd1 << INT_BITS);
		else
			c = v;
		r = {1'b0, c} + (CRD_W+1)'(64'd1 << (INT_BITS - FRAC_BITS - 1));
		return r[INT_BITS - FRAC_BITS + MAG_W - 1 : INT_BITS - FRAC_BITS];
	endfunction

endpackage

/* design/cst_quad_div.sv */
`timescale 1ns / 1ps
module cst_quad_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cst_pkg::NUM_W-1:0]    dividend,
	input  logic [cst_pkg::IDX_W-1:0]    divisor,
	output logic [1:0]                   quad,
	output logic [cst_pkg::IDX_W-1:0]    resid
);

	logic [cst_pkg::IDX_W-1:0] rem_s [cst_pkg::QD_STAGES];
	logic [cst_pkg::NUM_W-1:0] num_s [cst_pkg::QD_STAGES];
	logic [1:0]                quo_s [cst_pkg::QD_STAGES];

	// Restoring division, a few quotient bits per stage
	for (genvar g = 0; g < cst_pkg::QD_STAGES; g++) begin : g_stage
		logic [cst_pkg::IDX_W-1:0] rem_in;
		logic [cst_pkg::NUM_W-1:0] num_in;
		logic [1:0]                quo_in;
		logic [cst_pkg::IDX_W-1:0] rem_nx;
		logic [1:0]                quo_nx;

		if (g == 0) begin : g_head
			assign rem_in = '0;
			assign num_in = dividend;
			assign quo_in = '0;
		end else begin : g_body
			assign rem_in = rem_s[g-1];
			assign num_in = num_s[g-1];
			assign quo_in = quo_s[g-1];
		end

		always_comb begin
			logic [cst_pkg::IDX_W:0] sh;
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int t = 0; t < cst_pkg::QD_PER; t++) begin
				if (g * cst_pkg::QD_PER + t < cst_pkg::QD_BITS) begin
					sh = {rem_nx, num_in[cst_pkg::QD_BITS - 1 - (g * cst_pkg::QD_PER + t)]};
					if (sh >= {1'b0, divisor}) begin
						rem_nx = cst_pkg::IDX_W'(sh - {1'b0, divisor});
						quo_nx = {quo_nx[0], 1'b1};
					end else begin
						rem_nx = sh[cst_pkg::IDX_W-1:0];
						quo_nx = {quo_nx[0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				num_s[g] <= num_in;
				quo_s[g] <= quo_nx;
			end
		end
	end

	assign quad  = quo_s[cst_pkg::QD_STAGES-1];
	assign resid = rem_s[cst_pkg::QD_STAGES-1];

endmodule

/* design/cst_angle_div.sv */
`timescale 1ns / 1ps
module cst_angle_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cst_pkg::IDX_W-1:0]    resid,
	input  logic [1:0]                   quad_in,
	input  logic [cst_pkg::IDX_W-1:0]    slices,
	output logic [cst_pkg::ANG_W-1:0]    angle,
	output logic [1:0]                   quad_out
);

	localparam int PROD_W = cst_pkg::ANG_W + cst_pkg::IDX_W + 2;

	logic [PROD_W-1:0]          prod_s1;
	logic [1:0]                 quad_s1;
	logic [cst_pkg::IDX_W:0]    den;
	logic [cst_pkg::IDX_W:0]    rem_s [cst_pkg::AD_STAGES];
	logic [cst_pkg::ANG_W-1:0]  num_s [cst_pkg::AD_STAGES];
	logic [cst_pkg::ANG_W-1:0]  quo_s [cst_pkg::AD_STAGES];
	logic [1:0]                 qd_s  [cst_pkg::AD_STAGES];

	assign den = {slices, 1'b0};

	// Scale the residual by twice pi/2, plus half the divisor for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(PROD_W'(resid) * PROD_W'(cst_pkg::HALF_PI_X2))
			         + PROD_W'(slices);
			quad_s1 <= quad_in;
		end
	end

	// Divide by twice the slice count; the quotient is below 2^31
	for (genvar g = 0; g < cst_pkg::AD_STAGES; g++) begin : g_stage
		logic [cst_pkg::IDX_W:0]   rem_in;
		logic [cst_pkg::ANG_W-1:0] num_in;
		logic [cst_pkg::ANG_W-1:0] quo_in;
		logic [1:0]                qd_in;
		logic [cst_pkg::IDX_W:0]   rem_nx;
		logic [cst_pkg::ANG_W-1:0] quo_nx;

		if (g == 0) begin : g_head
			assign rem_in = prod_s1[cst_pkg::ANG_W + cst_pkg::IDX_W : cst_pkg::ANG_W];
			assign num_in = prod_s1[cst_pkg::ANG_W-1:0];
			assign quo_in = '0;
			assign qd_in  = quad_s1;
		end else begin : g_body
			assign rem_in = rem_s[g-1];
			assign num_in = num_s[g-1];
			assign quo_in = quo_s[g-1];
			assign qd_in  = qd_s[g-1];
		end

		always_comb begin
			logic [cst_pkg::IDX_W+1:0] sh;
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int t = 0; t < cst_pkg::AD_PER; t++) begin
				if (g * cst_pkg::AD_PER + t < cst_pkg::AD_BITS) begin
					sh = {rem_nx, num_in[cst_pkg::AD_BITS - 1 - (g * cst_pkg::AD_PER + t)]};
					if (sh >= {1'b0, den}) begin
						rem_nx = (cst_pkg::IDX_W+1)'(sh - {1'b0, den});
						quo_nx = {quo_nx[cst_pkg::ANG_W-2:0], 1'b1};
					end else begin
						rem_nx = sh[cst_pkg::IDX_W:0];
						quo_nx = {quo_nx[cst_pkg::ANG_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				num_s[g] <= num_in;
				quo_s[g] <= quo_nx;
				qd_s[g]  <= qd_in;
			end
		end
	end

	assign angle    = quo_s[cst_pkg::AD_STAGES-1];
	assign quad_out = qd_s[cst_pkg::AD_STAGES-1];

endmodule

/* design/cst_cordic.sv */
`timescale 1ns / 1ps
module cst_cordic (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cst_pkg::ANG_W-1:0]    angle,
	input  logic [1:0]                   quad,
	output cst_pkg::trig_t               trig
);

	localparam int W = cst_pkg::CRD_W;

	logic signed [W-1:0] x_s [cst_pkg::CD_STAGES];
	logic signed [W-1:0] y_s [cst_pkg::CD_STAGES];
	logic signed [W-1:0] z_s [cst_pkg::CD_STAGES];
	logic [1:0]          qd_s [cst_pkg::CD_STAGES];
	cst_pkg::trig_t      trig_q;

	// Rotation-mode iterations, a fixed shift per step
	for (genvar g = 0; g < cst_pkg::CD_STAGES; g++) begin : g_stage
		logic signed [W-1:0] x_in, y_in, z_in;
		logic [1:0]          qd_in;
		logic signed [W-1:0] x_nx, y_nx, z_nx;

		if (g == 0) begin : g_head
			assign x_in  = cst_pkg::CORDIC_GAIN;
			assign y_in  = '0;
			assign z_in  = signed'(W'(angle));
			assign qd_in = quad;
		end else begin : g_body
			assign x_in  = x_s[g-1];
			assign y_in  = y_s[g-1];
			assign z_in  = z_s[g-1];
			assign qd_in = qd_s[g-1];
		end

		always_comb begin
			logic signed [W-1:0] dx, dy;
			x_nx = x_in;
			y_nx = y_in;
			z_nx = z_in;
			for (int t = 0; t < cst_pkg::CD_PER; t++) begin
				if (g * cst_pkg::CD_PER + t < cst_pkg::CD_ITERS) begin
					dx = y_nx >>> (g * cst_pkg::CD_PER + t);
					dy = x_nx >>> (g * cst_pkg::CD_PER + t);
					if (!z_nx[W-1]) begin
						x_nx = x_nx - dx;
						y_nx = y_nx + dy;
						z_nx = z_nx - cst_pkg::arc_of(g * cst_pkg::CD_PER + t);
					end else begin
						x_nx = x_nx + dx;
						y_nx = y_nx - dy;
						z_nx = z_nx + cst_pkg::arc_of(g * cst_pkg::CD_PER + t);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g]  <= x_nx;
				y_s[g]  <= y_nx;
				z_s[g]  <= z_nx;
				qd_s[g] <= qd_in;
			end
		end
	end

	// Round to output format and unfold the quadrant
	always_ff @(posedge clk) begin
		logic signed [cst_pkg::OUT_W-1:0] a, b;
		a = signed'({1'b0, cst_pkg::to_out(y_s[cst_pkg::CD_STAGES-1])});
		b = signed'({1'b0, cst_pkg::to_out(x_s[cst_pkg::CD_STAGES-1])});
		if (en) begin
			case (qd_s[cst_pkg::CD_STAGES-1])
				2'd0: begin
					trig_q.sn <= a;
					trig_q.cs <= b;
				end
				2'd1: begin
					trig_q.sn <= b;
					trig_q.cs <= -a;
				end
				2'd2: begin
					trig_q.sn <= -a;
					trig_q.cs <= -b;
				end
				default: begin
					trig_q.sn <= -b;
					trig_q.cs <= a;
				end
			endcase
		end
	end

	assign trig = trig_q;

endmodule

/* design/cst_emit.sv */
`timescale 1ns / 1ps
module cst_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic [cst_pkg::IDX_W-1:0]     item_index,
	input  cst_pkg::trig_t                trig_first,
	input  cst_pkg::trig_t                trig_second,
	output logic                          take,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          result_kind,
	output logic signed [15:0]            vertex_x,
	output logic [14:0]                   vertex_y,
	output logic signed [15:0]            vertex_z,
	output logic signed [15:0]            normal_x,
	output logic signed [15:0]            normal_z,
	output logic [15:0]                   corner_a,
	output logic [15:0]                   corner_b,
	output logic [15:0]                   corner_c,
	output logic                          last
);

	logic                      busy_q;
	logic [2:0]                slot_q;
	logic [cst_pkg::IDX_W-1:0] idx_q;
	cst_pkg::trig_t            first_q;
	cst_pkg::trig_t            second_q;
	logic [15:0]               base;
	cst_pkg::trig_t            cur;

	// Free once the sixth result of the held request leaves
	assign take = !busy_q || (slot_q == cst_pkg::SLOT_TRI_B && !out_stall);

	// Hold the request and step through its six results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= '0;
		end else if (take) begin
			busy_q <= item_valid;
			slot_q <= '0;
		end else if (!out_stall) begin
			slot_q <= slot_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_valid) begin
			idx_q    <= item_index;
			first_q  <= trig_first;
			second_q <= trig_second;
		end
	end

	assign base = {idx_q, 2'b00};
	assign cur  = slot_q[0] ? second_q : first_q;

	// Drive the result fields for the current slot
	always_comb begin
		result_kind = cst_pkg::KIND_VERTEX;
		vertex_x    = '0;
		vertex_y    = '0;
		vertex_z    = '0;
		normal_x    = '0;
		normal_z    = '0;
		corner_a    = '0;
		corner_b    = '0;
		corner_c    = '0;
		last        = 1'b0;
		case (slot_q)
			cst_pkg::SLOT_TRI_A: begin
				result_kind = cst_pkg::KIND_TRIANGLE;
				corner_a    = base;
				corner_b    = base + 16'd3;
				corner_c    = base + 16'd1;
			end
			cst_pkg::SLOT_TRI_B: begin
				result_kind = cst_pkg::KIND_TRIANGLE;
				corner_a    = base;
				corner_b    = base + 16'd2;
				corner_c    = base + 16'd3;
				last        = 1'b1;
			end
			default: begin
				vertex_x = cur.sn;
				vertex_z = cur.cs;
				normal_x = cur.sn;
				normal_z = cur.cs;
				vertex_y = slot_q[1] ? '0 : cst_pkg::TOP_HEIGHT;
			end
		endcase
	end

	assign out_valid = busy_q;

endmodule

/* design/cylinder_slice_tessellator.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   slice_index
// result    out        out_valid / out_stall result_kind .. last (six per request)
// config    in         cfg_we                cfg_wdata (slice_count)
//
// A request yields six results, one per cycle while not stalled; the result port
// sets the sustained rate. Each request passes 31 pipeline stages (quadrant divide,
// angle scale and divide, 30 CORDIC rotations, rounding) before its first result.
// Reset clears the valid bits and sets slice_count to 16.
// A result stall freezes the pipeline only when its last stage holds a request.
module cylinder_slice_tessellator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [13:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [13:0]           slice_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  result_kind,
	output logic signed [15:0]    vertex_x,
	output logic [14:0]           vertex_y,
	output logic signed [15:0]    vertex_z,
	output logic signed [15:0]    normal_x,
	output logic signed [15:0]    normal_z,
	output logic [15:0]           corner_a,
	output logic [15:0]           corner_b,
	output logic [15:0]           corner_c,
	output logic                  last
);

	localparam int LAT = cst_pkg::LANE_LAT;

	logic [cst_pkg::IDX_W-1:0] slices_q;
	logic [cst_pkg::IDX_W-1:0] slices;
	logic                      adv;
	logic                      take;
	logic [cst_pkg::IDX_W:0]   next_idx;
	logic [cst_pkg::NUM_W-1:0] num_a, num_b;
	logic                      vld_q [LAT];
	logic [cst_pkg::IDX_W-1:0] idx_q [LAT];

	logic [1:0]                quad_a, quad_b, aquad_a, aquad_b;
	logic [cst_pkg::IDX_W-1:0] resid_a, resid_b;
	logic [cst_pkg::ANG_W-1:0] angle_a, angle_b;
	cst_pkg::trig_t            trig_a, trig_b;

	// Slice count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slices_q <= cst_pkg::IDX_W'(16);
		else if (cfg_we)
			slices_q <= cfg_wdata;
	end

	assign slices = (slices_q < cst_pkg::IDX_W'(cst_pkg::MIN_SLICES)) ?
		cst_pkg::IDX_W'(cst_pkg::MIN_SLICES) : slices_q;

	// Advance when the tail is empty or the emitter takes it
	assign adv      = !vld_q[LAT-1] || take;
	assign in_stall = !adv;

	// The far edge of the slice wraps to zero at the last slice
	assign next_idx = (slice_index == slices - cst_pkg::IDX_W'(1)) ? '0 :
		{1'b0, slice_index} + (cst_pkg::IDX_W+1)'(1);
	assign num_a = {1'b0, slice_index, 2'b00};
	assign num_b = {next_idx, 2'b00};

	// Valid bits and slice index travel alongside the lanes
	for (genvar g = 0; g < LAT; g++) begin : g_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[g] <= 1'b0;
			else if (adv)
				vld_q[g] <= (g == 0) ? in_valid : vld_q[(g == 0) ? 0 : g-1];
		end
		always_ff @(posedge clk) begin
			if (adv)
				idx_q[g] <= (g == 0) ? slice_index : idx_q[(g == 0) ? 0 : g-1];
		end
	end

	cst_quad_div u_quad_a (.clk, .en(adv), .dividend(num_a), .divisor(slices),
		.quad(quad_a), .resid(resid_a));
	cst_quad_div u_quad_b (.clk, .en(adv), .dividend(num_b), .divisor(slices),
		.quad(quad_b), .resid(resid_b));

	cst_angle_div u_angle_a (.clk, .en(adv), .resid(resid_a), .quad_in(quad_a),
		.slices, .angle(angle_a), .quad_out(aquad_a));
	cst_angle_div u_angle_b (.clk, .en(adv), .resid(resid_b), .quad_in(quad_b),
		.slices, .angle(angle_b), .quad_out(aquad_b));

	cst_cordic u_cordic_a (.clk, .en(adv), .angle(angle_a), .quad(aquad_a), .trig(trig_a));
	cst_cordic u_cordic_b (.clk, .en(adv), .angle(angle_b), .quad(aquad_b), .trig(trig_b));

	cst_emit u_emit (
		.clk, .arst_n,
		.item_valid(vld_q[LAT-1]), .item_index(idx_q[LAT-1]),
		.trig_first(trig_a), .trig_second(trig_b),
		.take, .out_valid, .out_stall,
		.result_kind, .vertex_x, .vertex_y, .vertex_z, .normal_x, .normal_z,
		.corner_a, .corner_b, .corner_c, .last
	);

	// Only the final triangle carries the end flag
	a_last_is_tri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> result_kind == cst_pkg::KIND_TRIANGLE)
		else $error("end flag on a vertex record");

	// Vertex records carry no corners
	a_vertex_corners: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == cst_pkg::KIND_VERTEX |-> corner_a == 16'd0
		&& corner_b == 16'd0 && corner_c == 16'd0)
		else $error("vertex record with corner indices");

	// A slice does not stop before its sixth result
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |=> out_valid)
		else $error("result sequence broken off");

	// The pipeline never moves while a full tail is refused
	a_hold_tail: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-1] && !take |=> vld_q[LAT-1] && $stable(idx_q[LAT-1]))
		else $error("tail request lost under stall");

endmodule

/* bench/tb_cylinder_slice_tessellator.sv */
`timescale 1ns / 1ps
module tb_cylinder_slice_tessellator;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam int DRAIN_CYCLES = 60;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam longint ARC_Q30 [11] = '{843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

	typedef struct {
		logic               kind;
		logic signed [15:0] vx;
		logic [14:0]        vy;
		logic signed [15:0] vz;
		logic signed [15:0] nx;
		logic signed [15:0] nz;
		logic [15:0]        ca;
		logic [15:0]        cb;
		logic [15:0]        cc;
		logic               lst;
	} mesh_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [13:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [13:0] slice_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic signed [15:0] vertex_x, vertex_z, normal_x, normal_z;
	logic [14:0] vertex_y;
	logic [15:0] corner_a, corner_b, corner_c;
	logic last;

	logic [13:0] slices_reg = 14'd16;
	logic [13:0] slice_q[$];
	mesh_rec_t mesh_q[$];
	int n_req = 0, n_res = 0, n_err = 0, n_cfg = 0;
	bit calm = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;
	int quiet_cnt = 0;

	cylinder_slice_tessellator u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sine and cosine of slice angle idx of s, Q1.14
	function automatic void slice_trig(input longint unsigned idx, input longint unsigned s,
		output logic signed [15:0] sn, output logic signed [15:0] cs);
		longint unsigned q, r;
		longint x, y, z, dx, dy, ak, a, b;
		q = ((idx * 4) / s) & 3;
		r = (idx * 4) % s;
		z = longint'((r * HALF_PI_Q30 * 2 + s) / (2 * s));
		x = GAIN_Q30;
		y = 0;
		for (int k = 0; k < cst_pkg::INT_BITS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			ak = (k < 11) ? ARC_Q30[k] : (64'sd1 <<< (cst_pkg::INT_BITS - k));
			if (z >= 0) begin
				x -= dx; y += dy; z -= ak;
			end else begin
				x += dx; y -= dy; z += ak;
			end
		end
		a = (y < 0) ? 0 : (y > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : y;
		b = (x < 0) ? 0 : (x > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : x;
		a = (a + (64'sd1 <<< 15)) >>> 16;
		b = (b + (64'sd1 <<< 15)) >>> 16;
		case (q)
			0: begin sn = a;  cs = b;  end
			1: begin sn = b;  cs = -a; end
			2: begin sn = -a; cs = -b; end
			default: begin sn = -b; cs = a; end
		endcase
	endfunction

	function automatic logic [15:0] sat_corner(input longint unsigned v);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	// Queue the six records one slice request produces
	function automatic void predict_slice(input logic [13:0] idx);
		longint unsigned s, i, j;
		logic signed [15:0] s1, c1, s2, c2;
		mesh_rec_t m;
		s = slices_reg;
		if (s < cst_pkg::MIN_SLICES) s = cst_pkg::MIN_SLICES;
		if (s > cst_pkg::MAX_SLICES) s = cst_pkg::MAX_SLICES;
		i = idx;
		j = (i == s - 1) ? 0 : i + 1;
		slice_trig(i, s, s1, c1);
		slice_trig(j, s, s2, c2);
		for (int k = 0; k < 4; k++) begin
			m = '{default: '0};
			m.kind = cst_pkg::KIND_VERTEX;
			m.vx = (k & 1) ? s2 : s1;
			m.vz = (k & 1) ? c2 : c1;
			m.nx = m.vx;
			m.nz = m.vz;
			m.vy = (k < 2) ? cst_pkg::TOP_HEIGHT : '0;
			mesh_q.push_back(m);
		end
		m = '{default: '0};
		m.kind = cst_pkg::KIND_TRIANGLE;
		m.ca = sat_corner(i * 4);
		m.cb = sat_corner(i * 4 + 3);
		m.cc = sat_corner(i * 4 + 1);
		mesh_q.push_back(m);
		m.cb = sat_corner(i * 4 + 2);
		m.cc = sat_corner(i * 4 + 3);
		m.lst = 1'b1;
		mesh_q.push_back(m);
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		n_err++;
	endtask

	function automatic bit gap_now();
		return !calm && ($urandom_range(99) < 14);
	endfunction

	// Request driver: advance on acceptance, hold while stalled
	always @(posedge clk) begin
		logic go;
		go = !in_valid || !in_stall;
		if (in_valid && !in_stall) begin
			predict_slice(slice_index);
			n_req++;
		end
		if (go) begin
			if (slice_q.size() != 0 && !gap_now()) begin
				slice_index <= slice_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, once, to back the pipeline up
	always @(posedge clk) begin
		if (!hold_done && n_req >= 150) begin
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Result monitor and receiver stall
	always @(posedge clk) begin
		mesh_rec_t e;
		if (out_valid && !out_stall) begin
			n_res++;
			if (mesh_q.size() == 0) begin
				report("unexpected result, kind", result_kind, -1);
			end else begin
				e = mesh_q.pop_front();
				if (result_kind !== e.kind) report("result_kind", result_kind, e.kind);
				if (vertex_x !== e.vx) report("vertex_x", vertex_x, e.vx);
				if (vertex_y !== e.vy) report("vertex_y", vertex_y, e.vy);
				if (vertex_z !== e.vz) report("vertex_z", vertex_z, e.vz);
				if (normal_x !== e.nx) report("normal_x", normal_x, e.nx);
				if (normal_z !== e.nz) report("normal_z", normal_z, e.nz);
				if (corner_a !== e.ca) report("corner_a", corner_a, e.ca);
				if (corner_b !== e.cb) report("corner_b", corner_b, e.cb);
				if (corner_c !== e.cc) report("corner_c", corner_c, e.cc);
				if (last !== e.lst) report("last", last, e.lst);
			end
		end
		out_stall <= (hold_cnt != 0) || gap_now();
	end

	// Watchdog on cycles with pending work and no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(slice_q.size() == 0 && !in_valid && mesh_q.size() == 0)) begin
			quiet_cnt <= 0;
		end else if (quiet_cnt >= STALL_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
		end
	end

	task automatic drain();
		while (slice_q.size() != 0 || in_valid || mesh_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_slices(input logic [13:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		slices_reg <= v;
		n_cfg++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly in-range slices, the wrapping slice often, some beyond the count
	task automatic queue_random(input int n);
		int s;
		int pick;
		s = (slices_reg < cst_pkg::MIN_SLICES) ? cst_pkg::MIN_SLICES : slices_reg;
		@(negedge clk);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 10) slice_q.push_back(s - 1);
			else if (pick < 85) slice_q.push_back($urandom_range(s - 1));
			else slice_q.push_back($urandom_range(16383));
		end
	endtask

	initial begin
		logic [13:0] counts[8];
		counts = '{14'd3, 14'd16383, 14'd0, 14'd1, 14'd2, 14'd7, 14'd1000, 14'd16383};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed requests at the reset count: ends, wrap, beyond the count
		slice_q.push_back(14'd0);
		slice_q.push_back(14'd1);
		slice_q.push_back(14'd4);
		slice_q.push_back(14'd8);
		slice_q.push_back(14'd12);
		slice_q.push_back(14'd15);
		slice_q.push_back(14'd16);
		slice_q.push_back(14'd17);
		slice_q.push_back(14'd8191);
		slice_q.push_back(14'd16383);
		slice_q.push_back(14'h2AAA);
		slice_q.push_back(14'h1555);
		drain();
		set_slices(14'd16383);
		@(negedge clk);
		slice_q.push_back(14'd0);
		slice_q.push_back(14'd16382);
		slice_q.push_back(14'd4096);
		slice_q.push_back(14'd12287);
		slice_q.push_back(14'd16383);
		drain();
		set_slices(14'd3);
		@(negedge clk);
		slice_q.push_back(14'd0);
		slice_q.push_back(14'd2);
		slice_q.push_back(14'd3);
		drain();
		// Random phases across several counts, extremes among them
		foreach (counts[k]) begin
			set_slices(counts[k]);
			if (k == 1) calm = 1'b1;
			if (k == 3) calm = 1'b0;
			queue_random(58);
			drain();
		end
		set_slices($urandom_range(16383));
		queue_random(20);
		drain();
		$display("covered %0d slice requests, %0d results, %0d count writes",
			n_req, n_res, n_cfg);
		$display("counts from below the minimum to the maximum, with one long result hold-off");
		if (n_err == 0 && mesh_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

/* files.f */
design/cst_pkg.sv
design/cst_quad_div.sv
design/cst_angle_div.sv
design/cst_cordic.sv
design/cst_emit.sv
design/cylinder_slice_tessellator.sv
bench/tb_cylinder_slice_tessellator.sv
